// ----- hdl/tsm_pkg.sv -----
// ----------------------------------------------------------------------------
// tsm_pkg
// Types and constants shared by the tilt stick mapper and its channels.
// ----------------------------------------------------------------------------
package tsm_pkg;

   localparam int AXIS_W = 16;
   localparam int DPAD_W = 4;
   localparam int NUM_AXES = 4;
   localparam int FACTOR_W = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 32;

   // Full-scale axis value reported for a single positive press.
   localparam logic [AXIS_W-1:0] AXIS_MAX = 16'd65535;
   localparam logic [AXIS_W-1:0] MID_RESET = 16'd32768;

   // Datapath widths of the tilt arithmetic.
   localparam int DIFF_W = AXIS_W + 1;
   localparam int GAIN_W = FACTOR_W + 1;
   localparam int NUM_W = DIFF_W + GAIN_W;
   localparam int DIV_W = 24;
   localparam int RECIP_W = 25;
   localparam int RECIP_SHIFT = 31;
   localparam int QUO_W = DIV_W + RECIP_W - RECIP_SHIFT;
   localparam int SUM_W = AXIS_W + 4;

   localparam logic [GAIN_W-1:0] PERCENT_FULL = 9'd100;
   localparam logic [NUM_W-1:0] ROUND_UP_99 = 26'd99;
   // ceil(2^31 / 100): exact floor division by 100 for dividends below 2^24.
   localparam logic [RECIP_W-1:0] RECIP_100 = 25'd21474837;

   typedef enum logic [1:0] {
      SOCD_UP_PRIORITY = 2'd0,
      SOCD_NEUTRAL     = 2'd1,
      SOCD_LAST_INPUT  = 2'd2,
      SOCD_NO_RULE     = 2'd3
   } socd_mode_type;

   typedef enum logic [1:0] {
      DIR_NONE   = 2'd0,
      DIR_FIRST  = 2'd1,
      DIR_SECOND = 2'd2
   } dir_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_SOCD_MODE = 2'd0,
      REG_MID_VALUE = 2'd1,
      REG_TILT_ONE  = 2'd2,
      REG_TILT_TWO  = 2'd3
   } csr_index_type;

endpackage

// ----- hdl/tsm_req_if.sv -----
// ----------------------------------------------------------------------------
// tsm_req_if
// Button scan channel: one debounced scan of the ten buttons per item.
// ----------------------------------------------------------------------------
interface tsm_req_if;
   logic valid;
   logic ready;
   logic left_x_neg;
   logic left_x_pos;
   logic left_y_neg;
   logic left_y_pos;
   logic right_x_neg;
   logic right_x_pos;
   logic right_y_neg;
   logic right_y_pos;
   logic mod_low;
   logic mod_high;

   modport source (
      output valid, left_x_neg, left_x_pos, left_y_neg, left_y_pos,
             right_x_neg, right_x_pos, right_y_neg, right_y_pos, mod_low, mod_high,
      input  ready
   );

   modport sink (
      input  valid, left_x_neg, left_x_pos, left_y_neg, left_y_pos,
             right_x_neg, right_x_pos, right_y_neg, right_y_pos, mod_low, mod_high,
      output ready
   );
endinterface

// ----- hdl/tsm_rsp_if.sv -----
// ----------------------------------------------------------------------------
// tsm_rsp_if
// Stick report channel: four axis values and a dpad override per item.
// ----------------------------------------------------------------------------
interface tsm_rsp_if
   import tsm_pkg::*;
;
   logic              valid;
   logic              ready;
   logic [AXIS_W-1:0] left_x;
   logic [AXIS_W-1:0] left_y;
   logic [AXIS_W-1:0] right_x;
   logic [AXIS_W-1:0] right_y;
   logic [DPAD_W-1:0] dpad_override;

   modport source (
      output valid, left_x, left_y, right_x, right_y, dpad_override,
      input  ready
   );

   modport sink (
      input  valid, left_x, left_y, right_x, right_y, dpad_override,
      output ready
   );
endinterface

// ----- hdl/tilt_stick_socd_mapper_core.sv -----
// ----------------------------------------------------------------------------
// tilt_stick_socd_mapper_core
// Maps a digital button scan to analog stick values with tilt modifiers,
// and SOCD-cleans the right-stick buttons into a dpad override.
// ----------------------------------------------------------------------------
//
//   Channel    Direction   Handshake          Content
//   req_chan   in          valid / ready      ten button bits
//   rsp_chan   out         valid / ready      four axes, dpad override
//   csr_*      in          csr_we             socd mode, mid, tilt factors
//
// One item per cycle is sustained while the report channel is ready. The pipeline
// has an input stage (button decode, SOCD cleaning, factor select), a multiply stage and a
// divide-by-100 and saturate stage that feeds the output register.
// Each stage holds its item only while the stage after it is full and
// stalled, so bubbles close up and a waiting result does not block intake.
// Reset clears the stage valids and the SOCD history and loads the register
// defaults (mid value 32768, everything else zero).
//
module tilt_stick_socd_mapper_core
   import tsm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   tsm_req_if.sink                req_chan,
   tsm_rsp_if.source              rsp_chan
);

   // Configuration registers.
   socd_mode_type                  socd_mode_ff, socd_mode_in;
   logic [AXIS_W-1:0]              mid_value_ff, mid_value_in;
   logic [CSR_DATA_W-1:0]          tilt_one_ff, tilt_one_in;
   logic [CSR_DATA_W-1:0]          tilt_two_ff, tilt_two_in;

   // SOCD history.
   dir_type                        last_vert_ff, last_vert_in;
   dir_type                        last_horz_ff, last_horz_in;

   // Pipeline control.
   logic                           s1_valid_ff, s1_valid_in;
   logic                           s2_valid_ff, s2_valid_in;
   logic                           out_valid_ff, out_valid_in;
   logic                           s1_en, s2_en, out_en, accept;

   // Stage payloads.
   logic [AXIS_W-1:0]              s1_axis_ff [NUM_AXES], s1_axis_in [NUM_AXES];
   logic signed [DIFF_W-1:0]       s1_diff_ff [NUM_AXES], s1_diff_in [NUM_AXES];
   logic signed [GAIN_W-1:0]       s1_gain_ff [NUM_AXES], s1_gain_in [NUM_AXES];
   logic [DPAD_W-1:0]              s1_dpad_ff, s1_dpad_in;
   logic [AXIS_W-1:0]              s2_axis_ff [NUM_AXES], s2_axis_in [NUM_AXES];
   logic signed [NUM_W-1:0]        s2_num_ff [NUM_AXES], s2_num_in [NUM_AXES];
   logic [DPAD_W-1:0]              s2_dpad_ff, s2_dpad_in;
   logic [AXIS_W-1:0]              out_axis_ff [NUM_AXES], out_axis_in [NUM_AXES];
   logic [DPAD_W-1:0]              out_dpad_ff, out_dpad_in;

   // Input stage decode.
   logic                           up, down, left, right;
   logic                           keep_up, keep_down, keep_left, keep_right;
   logic [DPAD_W-1:0]              cleaned;
   logic                           hold_mid, tilt;
   logic [CSR_DATA_W-1:0]          factors;
   logic [NUM_AXES-1:0]            btn_neg, btn_pos;

   // ------------------------------------------------------------------------
   // Handshake.
   // ------------------------------------------------------------------------
   always_comb begin
      out_en = !out_valid_ff || rsp_chan.ready;
      s2_en = !s2_valid_ff || out_en;
      s1_en = !s1_valid_ff || s2_en;
      accept = req_chan.valid && s1_en;

      s1_valid_in = s1_en ? req_chan.valid : s1_valid_ff;
      s2_valid_in = s2_en ? s1_valid_ff : s2_valid_ff;
      out_valid_in = out_en ? s2_valid_ff : out_valid_ff;
   end

   assign req_chan.ready = s1_en;

   // ------------------------------------------------------------------------
   // Configuration writes.
   // ------------------------------------------------------------------------
   always_comb begin
      socd_mode_in = socd_mode_ff;
      mid_value_in = mid_value_ff;
      tilt_one_in = tilt_one_ff;
      tilt_two_in = tilt_two_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            REG_SOCD_MODE: socd_mode_in = socd_mode_type'(csr_wdata[1:0]);
            REG_MID_VALUE: mid_value_in = csr_wdata[AXIS_W-1:0];
            REG_TILT_ONE:  tilt_one_in = csr_wdata;
            REG_TILT_TWO:  tilt_two_in = csr_wdata;
            default:       socd_mode_in = socd_mode_ff;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // SOCD cleaning of the right-stick buttons.
   // ------------------------------------------------------------------------
   always_comb begin
      up = req_chan.right_y_neg;
      down = req_chan.right_y_pos;
      left = req_chan.right_x_neg;
      right = req_chan.right_x_pos;

      keep_up = up;
      keep_down = down;
      last_vert_in = last_vert_ff;
      case ({up, down})
         2'b11: begin
            if (socd_mode_ff == SOCD_UP_PRIORITY) begin
               keep_down = 1'b0;
               last_vert_in = DIR_FIRST;
            end else if (socd_mode_ff == SOCD_LAST_INPUT && last_vert_ff != DIR_NONE) begin
               // The direction seen last loses to the newly added one.
               if (last_vert_ff == DIR_FIRST) begin
                  keep_up = 1'b0;
               end else begin
                  keep_down = 1'b0;
               end
            end else begin
               keep_up = 1'b0;
               keep_down = 1'b0;
               last_vert_in = DIR_NONE;
            end
         end
         2'b10:   last_vert_in = DIR_FIRST;
         2'b01:   last_vert_in = DIR_SECOND;
         default: last_vert_in = DIR_NONE;
      endcase

      keep_left = left;
      keep_right = right;
      last_horz_in = last_horz_ff;
      case ({left, right})
         2'b11: begin
            case (socd_mode_ff) inside
               SOCD_UP_PRIORITY, SOCD_NEUTRAL: begin
                  keep_left = 1'b0;
                  keep_right = 1'b0;
                  last_horz_in = DIR_NONE;
               end
               SOCD_LAST_INPUT: begin
                  if (last_horz_ff == DIR_FIRST) begin
                     keep_left = 1'b0;
                  end else if (last_horz_ff != DIR_NONE) begin
                     keep_right = 1'b0;
                  end
               end
               default: keep_left = left;
            endcase
         end
         2'b10:   last_horz_in = DIR_FIRST;
         2'b01:   last_horz_in = DIR_SECOND;
         default: last_horz_in = DIR_NONE;
      endcase

      if (!accept) begin
         last_vert_in = last_vert_ff;
         last_horz_in = last_horz_ff;
      end

      cleaned = {keep_right, keep_left, keep_down, keep_up};
   end

   // ------------------------------------------------------------------------
   // Input stage: raw axes, modifier selection and per-axis gain.
   // Every path is written as a + floor((mid - a) * g / 100), with g = 0
   // when no tilt applies.
   // ------------------------------------------------------------------------
   always_comb begin
      btn_neg = {req_chan.right_y_neg, req_chan.right_x_neg,
                 req_chan.left_y_neg, req_chan.left_x_neg};
      btn_pos = {req_chan.right_y_pos, req_chan.right_x_pos,
                 req_chan.left_y_pos, req_chan.left_x_pos};

      hold_mid = 1'b0;
      tilt = 1'b0;
      factors = tilt_one_ff;
      if (req_chan.mod_low && req_chan.mod_high) begin
         if (cleaned != '0) begin
            hold_mid = 1'b1;
         end else begin
            tilt = 1'b1;
         end
      end else if (req_chan.mod_low) begin
         tilt = 1'b1;
      end else if (req_chan.mod_high) begin
         tilt = 1'b1;
         factors = tilt_two_ff;
      end

      s1_dpad_in = hold_mid ? cleaned : '0;

      for (int i = 0; i < NUM_AXES; i++) begin
         if (hold_mid) begin
            s1_axis_in[i] = mid_value_ff;
         end else if (btn_neg[i] && !btn_pos[i]) begin
            s1_axis_in[i] = '0;
         end else if (!btn_neg[i] && btn_pos[i]) begin
            s1_axis_in[i] = AXIS_MAX;
         end else begin
            s1_axis_in[i] = mid_value_ff;
         end
         s1_diff_in[i] = $signed({1'b0, mid_value_ff}) - $signed({1'b0, s1_axis_in[i]});
         s1_gain_in[i] = tilt ? $signed(PERCENT_FULL) -
                                $signed({1'b0, factors[FACTOR_W*i +: FACTOR_W]})
                              : '0;
      end
   end

   // ------------------------------------------------------------------------
   // Multiply stage.
   // ------------------------------------------------------------------------
   always_comb begin
      s2_dpad_in = s1_dpad_ff;
      for (int i = 0; i < NUM_AXES; i++) begin
         s2_axis_in[i] = s1_axis_ff[i];
         s2_num_in[i] = s1_diff_ff[i] * s1_gain_ff[i];
      end
   end

   // ------------------------------------------------------------------------
   // Floor divide by 100 through a reciprocal, add and saturate.
   // A negative dividend is floored as -ceil(|n| / 100).
   // ------------------------------------------------------------------------
   logic                           neg [NUM_AXES];
   logic [NUM_W-1:0]               mag [NUM_AXES];
   logic [DIV_W+RECIP_W-1:0]       prod [NUM_AXES];
   logic [QUO_W-1:0]               quo [NUM_AXES];
   logic signed [SUM_W-1:0]        quo_s [NUM_AXES];
   logic signed [SUM_W-1:0]        sum [NUM_AXES];

   always_comb begin
      out_dpad_in = s2_dpad_ff;
      for (int i = 0; i < NUM_AXES; i++) begin
         neg[i] = s2_num_ff[i][NUM_W-1];
         mag[i] = neg[i] ? NUM_W'(-s2_num_ff[i]) + ROUND_UP_99 : NUM_W'(s2_num_ff[i]);
         prod[i] = mag[i][DIV_W-1:0] * RECIP_100;
         quo[i] = prod[i][RECIP_SHIFT +: QUO_W];
         quo_s[i] = neg[i] ? -$signed({2'b00, quo[i]}) : $signed({2'b00, quo[i]});
         sum[i] = $signed({4'b0000, s2_axis_ff[i]}) + quo_s[i];
         if (sum[i][SUM_W-1]) begin
            out_axis_in[i] = '0;
         end else if (sum[i] > $signed({4'b0000, AXIS_MAX})) begin
            out_axis_in[i] = AXIS_MAX;
         end else begin
            out_axis_in[i] = sum[i][AXIS_W-1:0];
         end
      end
   end

   // ------------------------------------------------------------------------
   // Registers.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         socd_mode_ff <= SOCD_UP_PRIORITY;
         mid_value_ff <= MID_RESET;
         tilt_one_ff <= '0;
         tilt_two_ff <= '0;
         last_vert_ff <= DIR_NONE;
         last_horz_ff <= DIR_NONE;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         socd_mode_ff <= socd_mode_in;
         mid_value_ff <= mid_value_in;
         tilt_one_ff <= tilt_one_in;
         tilt_two_ff <= tilt_two_in;
         last_vert_ff <= last_vert_in;
         last_horz_ff <= last_horz_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_axis_ff <= s1_axis_in;
         s1_diff_ff <= s1_diff_in;
         s1_gain_ff <= s1_gain_in;
         s1_dpad_ff <= s1_dpad_in;
      end
      if (s2_en) begin
         s2_axis_ff <= s2_axis_in;
         s2_num_ff <= s2_num_in;
         s2_dpad_ff <= s2_dpad_in;
      end
      if (out_en) begin
         out_axis_ff <= out_axis_in;
         out_dpad_ff <= out_dpad_in;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.left_x = out_axis_ff[0];
   assign rsp_chan.left_y = out_axis_ff[1];
   assign rsp_chan.right_x = out_axis_ff[2];
   assign rsp_chan.right_y = out_axis_ff[3];
   assign rsp_chan.dpad_override = out_dpad_ff;

endmodule

// ----- bench/tb_tilt_stick_socd_mapper_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tilt_stick_socd_mapper_core
// Drives button scans into the tilt stick mapper under a range of SOCD modes,
// mid values and tilt factors, predicts each stick report in a scoreboard and
// compares the reports field by field, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_tilt_stick_socd_mapper_core;
   import tsm_pkg::*;

   localparam logic [DPAD_W-1:0] DPAD_UP    = 4'b0001;
   localparam logic [DPAD_W-1:0] DPAD_DOWN  = 4'b0010;
   localparam logic [DPAD_W-1:0] DPAD_LEFT  = 4'b0100;
   localparam logic [DPAD_W-1:0] DPAD_RIGHT = 4'b1000;
   localparam int NUM_PHASES = 6;
   localparam int PHASE_SCANS = 250;
   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_OFF_CYCLES = 300;

   typedef struct packed {
      logic mod_high;
      logic mod_low;
      logic right_y_pos;
      logic right_y_neg;
      logic right_x_pos;
      logic right_x_neg;
      logic left_y_pos;
      logic left_y_neg;
      logic left_x_pos;
      logic left_x_neg;
   } scan_type;

   typedef struct packed {
      logic [AXIS_W-1:0] left_x;
      logic [AXIS_W-1:0] left_y;
      logic [AXIS_W-1:0] right_x;
      logic [AXIS_W-1:0] right_y;
      logic [DPAD_W-1:0] dpad;
   } report_type;

   class stick_scoreboard;
      socd_mode_type     mode;
      logic [AXIS_W-1:0] mid;
      logic [31:0]       tilt_one;
      logic [31:0]       tilt_two;
      dir_type           last_v;
      dir_type           last_h;
      report_type        pending[$];
      int                mismatches;
      int                n_scans;
      int                n_tilted;
      int                n_dpad;

      function new();
         mode = SOCD_UP_PRIORITY;
         mid = MID_RESET;
         tilt_one = '0;
         tilt_two = '0;
         last_v = DIR_NONE;
         last_h = DIR_NONE;
         mismatches = 0;
         n_scans = 0;
         n_tilted = 0;
         n_dpad = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_SOCD_MODE: mode = socd_mode_type'(data[1:0]);
            REG_MID_VALUE: mid = data[AXIS_W-1:0];
            REG_TILT_ONE:  tilt_one = data;
            REG_TILT_TWO:  tilt_two = data;
            default: ;
         endcase
      endfunction

      function logic [AXIS_W-1:0] raw_axis(logic n, logic p);
         if (n && !p) return '0;
         if (!n && p) return AXIS_MAX;
         return mid;
      endfunction

      // Pull the axis toward mid by (100 - f) percent, floored, then saturate.
      function logic [AXIS_W-1:0] tilt_axis(logic [AXIS_W-1:0] a, logic [7:0] f);
         longint num;
         longint q;
         longint v;
         num = (longint'(mid) - longint'(a)) * (longint'(100) - longint'(f));
         q = num / 100;
         if (num % 100 != 0 && num < 0) q = q - 1;
         v = longint'(a) + q;
         if (v < 0) return '0;
         if (v > longint'(AXIS_MAX)) return AXIS_MAX;
         return v[AXIS_W-1:0];
      endfunction

      function logic [DPAD_W-1:0] clean_right(logic [DPAD_W-1:0] s);
         case (s & (DPAD_UP | DPAD_DOWN))
            DPAD_UP | DPAD_DOWN: begin
               if (mode == SOCD_UP_PRIORITY) begin
                  s &= ~DPAD_DOWN;
                  last_v = DIR_FIRST;
               end else if (mode == SOCD_LAST_INPUT && last_v != DIR_NONE) begin
                  s &= ~((last_v == DIR_FIRST) ? DPAD_UP : DPAD_DOWN);
               end else begin
                  s &= ~(DPAD_UP | DPAD_DOWN);
                  last_v = DIR_NONE;
               end
            end
            DPAD_UP:   last_v = DIR_FIRST;
            DPAD_DOWN: last_v = DIR_SECOND;
            default:   last_v = DIR_NONE;
         endcase
         case (s & (DPAD_LEFT | DPAD_RIGHT))
            DPAD_LEFT | DPAD_RIGHT: begin
               if (mode == SOCD_UP_PRIORITY || mode == SOCD_NEUTRAL) begin
                  s &= ~(DPAD_LEFT | DPAD_RIGHT);
                  last_h = DIR_NONE;
               end else if (mode == SOCD_LAST_INPUT && last_h != DIR_NONE) begin
                  s &= ~((last_h == DIR_FIRST) ? DPAD_LEFT : DPAD_RIGHT);
               end
            end
            DPAD_LEFT:  last_h = DIR_FIRST;
            DPAD_RIGHT: last_h = DIR_SECOND;
            default:    last_h = DIR_NONE;
         endcase
         return s;
      endfunction

      function void note_scan(scan_type s);
         logic [AXIS_W-1:0] ax[NUM_AXES];
         logic [DPAD_W-1:0] right;
         logic [31:0]       factors;
         logic              tilt;
         report_type        r;
         ax[0] = raw_axis(s.left_x_neg, s.left_x_pos);
         ax[1] = raw_axis(s.left_y_neg, s.left_y_pos);
         ax[2] = raw_axis(s.right_x_neg, s.right_x_pos);
         ax[3] = raw_axis(s.right_y_neg, s.right_y_pos);
         right = '0;
         if (s.right_x_neg) right |= DPAD_LEFT;
         if (s.right_x_pos) right |= DPAD_RIGHT;
         if (s.right_y_neg) right |= DPAD_UP;
         if (s.right_y_pos) right |= DPAD_DOWN;
         right = clean_right(right);
         tilt = 1'b0;
         factors = '0;
         r.dpad = '0;
         // Both modifiers with nothing left after cleaning fall back to tilt one.
         if (s.mod_low && s.mod_high && right != '0) begin
            r.dpad = right;
         end else if (s.mod_low) begin
            tilt = 1'b1;
            factors = tilt_one;
         end else if (s.mod_high) begin
            tilt = 1'b1;
            factors = tilt_two;
         end
         for (int i = 0; i < NUM_AXES; i++) begin
            if (r.dpad != '0) ax[i] = mid;
            else if (tilt) ax[i] = tilt_axis(ax[i], factors[8*i +: 8]);
         end
         r.left_x = ax[0];
         r.left_y = ax[1];
         r.right_x = ax[2];
         r.right_y = ax[3];
         pending.push_back(r);
         n_scans++;
         if (tilt) n_tilted++;
         if (r.dpad != '0) n_dpad++;
      endfunction

      function void check_report(report_type got);
         report_type want;
         if (pending.size() == 0) begin
            if (mismatches < 10)
               $display("%0t: report with no scan outstanding: %h", $realtime, got);
            mismatches++;
         end else begin
            want = pending.pop_front();
            if (got.left_x !== want.left_x || got.left_y !== want.left_y ||
                got.right_x !== want.right_x || got.right_y !== want.right_y ||
                got.dpad !== want.dpad) begin
               if (mismatches < 10)
                  $display("%0t: expected lx %h ly %h rx %h ry %h dpad %h, got %h %h %h %h %h",
                           $realtime, want.left_x, want.left_y, want.right_x,
                           want.right_y, want.dpad, got.left_x, got.left_y,
                           got.right_x, got.right_y, got.dpad);
               mismatches++;
            end
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     send_idle_pct;
   int                     recv_idle_pct;
   int                     hold_off_left;
   int                     quiet_cycles;
   stick_scoreboard        board = new();

   tsm_req_if req_bus ();
   tsm_rsp_if rsp_bus ();

   tilt_stick_socd_mapper_core uut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Receiver: random back-pressure, plus a long hold-off when one is requested.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_off_left--;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Check reports before noting scans, since a report always stems from an older scan.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready)
            board.check_report({rsp_bus.left_x, rsp_bus.left_y, rsp_bus.right_x,
                                rsp_bus.right_y, rsp_bus.dpad_override});
         if (req_bus.valid && req_bus.ready)
            board.note_scan({req_bus.mod_high, req_bus.mod_low, req_bus.right_y_pos,
                             req_bus.right_y_neg, req_bus.right_x_pos, req_bus.right_x_neg,
                             req_bus.left_y_pos, req_bus.left_y_neg, req_bus.left_x_pos,
                             req_bus.left_x_neg});
         if ((rsp_bus.valid && rsp_bus.ready) || (req_bus.valid && req_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // Called at a falling edge; returns at a falling edge.
   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      board.set_reg(idx, data);
      @(negedge clock);
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance
   // with valid still high, so the next call makes the only change to it.
   task automatic send_scan(scan_type s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.left_x_neg <= s.left_x_neg;
      req_bus.left_x_pos <= s.left_x_pos;
      req_bus.left_y_neg <= s.left_y_neg;
      req_bus.left_y_pos <= s.left_y_pos;
      req_bus.right_x_neg <= s.right_x_neg;
      req_bus.right_x_pos <= s.right_x_pos;
      req_bus.right_y_neg <= s.right_y_neg;
      req_bus.right_y_pos <= s.right_y_pos;
      req_bus.mod_low <= s.mod_low;
      req_bus.mod_high <= s.mod_high;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   initial begin
      logic [9:0]        directed[24];
      socd_mode_type     mode_tab[NUM_PHASES];
      logic [AXIS_W-1:0] mid_tab[NUM_PHASES];
      logic [31:0]       tilt_one_tab[NUM_PHASES];
      logic [31:0]       tilt_two_tab[NUM_PHASES];
      int                send_tab[3];
      int                recv_tab[3];
      logic [9:0]        bits;
      logic [9:0]        prev_bits;

      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = REG_SOCD_MODE;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      {req_bus.mod_high, req_bus.mod_low, req_bus.right_y_pos, req_bus.right_y_neg,
       req_bus.right_x_pos, req_bus.right_x_neg, req_bus.left_y_pos,
       req_bus.left_y_neg, req_bus.left_x_pos, req_bus.left_x_neg} = '0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_off_left = 0;
      quiet_cycles = 0;

      // Bit order: mod_high, mod_low, right y pos/neg, right x pos/neg,
      // left y pos/neg, left x pos/neg.
      directed = '{10'h000, 10'h001, 10'h002, 10'h004, 10'h008, 10'h010,
                   10'h020, 10'h040, 10'h080, 10'h100, 10'h200, 10'h3FF,
                   10'h340, 10'h3C0, 10'h380, 10'h3C0, 10'h310, 10'h330,
                   10'h320, 10'h330, 10'h300, 10'h330, 10'h103, 10'h20F};
      mode_tab = '{SOCD_NEUTRAL, SOCD_LAST_INPUT, SOCD_NO_RULE,
                   SOCD_UP_PRIORITY, SOCD_LAST_INPUT, SOCD_NO_RULE};
      mid_tab = '{16'h0000, 16'hFFFF, MID_RESET, 16'($urandom), 16'h0001, 16'($urandom)};
      tilt_one_tab = '{32'hFFFF_FFFF, 32'h6464_6464, $urandom, $urandom,
                       32'h0000_0000, $urandom};
      tilt_two_tab = '{32'h0000_0000, 32'h6500_FF01, $urandom, $urandom,
                       32'hFFFF_FFFF, $urandom};
      // Sender idles lightly while the receiver stalls heavily, then the reverse, then neither idles.
      send_tab = '{32, 76, 0};
      recv_tab = '{76, 32, 0};

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed scans in last input priority mode, where the history matters.
      write_reg(REG_SOCD_MODE, 32'(SOCD_LAST_INPUT));
      write_reg(REG_TILT_ONE, 32'h3264_FF00);
      write_reg(REG_TILT_TWO, 32'h01C8_6525);
      foreach (directed[i]) send_scan(scan_type'(directed[i]));
      drain();

      prev_bits = '0;
      for (int p = 0; p < NUM_PHASES; p++) begin
         write_reg(REG_SOCD_MODE, 32'(mode_tab[p]));
         write_reg(REG_MID_VALUE, 32'(mid_tab[p]));
         if (p == 3)
            write_reg(REG_TILT_TWO, {8'($urandom_range(100)), 8'($urandom_range(100)),
                                     8'($urandom_range(100)), 8'($urandom_range(100))});
         else
            write_reg(REG_TILT_TWO, tilt_two_tab[p]);
         write_reg(REG_TILT_ONE, tilt_one_tab[p]);
         send_idle_pct = send_tab[p / 2];
         recv_idle_pct = recv_tab[p / 2];
         // With the sender never idle, a long receiver hold-off fills the pipeline.
         if (p == 4) hold_off_left = HOLD_OFF_CYCLES;
         for (int n = 0; n < PHASE_SCANS; n++) begin
            bits = 10'($urandom);
            // Half the time press or release one right-stick button relative to
            // the last scan, so the SOCD history sees realistic sequences.
            if ($urandom_range(1) == 1)
               bits[7:4] = prev_bits[7:4] ^ (4'b0001 << $urandom_range(3));
            prev_bits = bits;
            send_scan(scan_type'(bits));
         end
         drain();
      end

      repeat (10) @(posedge clock);
      $display("Ran %0d scans over all four SOCD modes and mid values from 0 to full scale.",
               board.n_scans);
      $display("%0d scans were tilted and %0d produced a dpad override; %0d mismatches.",
               board.n_tilted, board.n_dpad, board.mismatches);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/tsm_pkg.sv
hdl/tsm_req_if.sv
hdl/tsm_rsp_if.sv
hdl/tilt_stick_socd_mapper_core.sv
bench/tb_tilt_stick_socd_mapper_core.sv
